// File: src/ddo_pkg.sv
package ddo_pkg;

   // Register file
   localparam int CFG_W      = 24;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [CFG_W-1:0] MM_PER_TICK_RESET  = 24'd10762;
   localparam logic [CFG_W-1:0] ANGLE_PER_MM_RESET = 24'd2629116;
   localparam logic REG_MM_PER_TICK  = 1'b0;
   localparam logic REG_ANGLE_PER_MM = 1'b1;

   // Datapath widths
   localparam int COUNT_W  = 32;
   localparam int DELTA_W  = 34;   // sum or difference of two 32-bit deltas
   localparam int MUL_A_W  = 34;
   localparam int MUL_B_W  = 33;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;
   localparam int TRAVEL_W = 48;
   localparam int TRAVEL_SHIFT = 9;
   localparam int SPLIT_T  = 24;   // travel split point for the pose products
   localparam int SPLIT_H  = 28;   // split point for the heading product
   localparam int HEAD_W   = 56;   // heading product kept modulo 2^56
   localparam int ACC_W    = 62;   // pose product kept modulo 2^62
   localparam int POSE_W   = 32;
   localparam int POSE_SHIFT = 30;
   localparam int HOUT_W   = 16;

   // CORDIC
   localparam int CORDIC_W     = 32;
   localparam int ATAN_ENTRIES = 24;
   localparam int ATAN_IDX_W   = 5;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 32'sh26DD3B6A;

   localparam logic [1:0] QUAD_ZERO          = 2'd0;
   localparam logic [1:0] QUAD_QUARTER       = 2'd1;
   localparam logic [1:0] QUAD_HALF          = 2'd2;
   localparam logic [1:0] QUAD_THREE_QUARTER = 2'd3;

   // arctan(2^-i) in 2^-32 turn units
   function automatic logic [CORDIC_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
      logic [CORDIC_W-1:0] v;
      case (idx)
         5'd0:    v = 32'h20000000;
         5'd1:    v = 32'h12E4051E;
         5'd2:    v = 32'h09FB385B;
         5'd3:    v = 32'h051111D4;
         5'd4:    v = 32'h028B0D43;
         5'd5:    v = 32'h0145D7E1;
         5'd6:    v = 32'h00A2F61E;
         5'd7:    v = 32'h00517C55;
         5'd8:    v = 32'h0028BE53;
         5'd9:    v = 32'h00145F2F;
         5'd10:   v = 32'h000A2F98;
         5'd11:   v = 32'h000517CC;
         5'd12:   v = 32'h00028BE6;
         5'd13:   v = 32'h000145F3;
         5'd14:   v = 32'h0000A2FA;
         5'd15:   v = 32'h0000517D;
         5'd16:   v = 32'h000028BE;
         5'd17:   v = 32'h0000145F;
         5'd18:   v = 32'h00000A30;
         5'd19:   v = 32'h00000518;
         5'd20:   v = 32'h0000028C;
         5'd21:   v = 32'h00000146;
         5'd22:   v = 32'h000000A3;
         5'd23:   v = 32'h00000051;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Operand pairs for the shared multiplier
   typedef enum logic [2:0] {
      MUL_SUM_MM,
      MUL_DIFF_MM,
      MUL_HEAD_LO,
      MUL_HEAD_HI,
      MUL_TRAV_LO_COS,
      MUL_TRAV_HI_COS,
      MUL_TRAV_LO_SIN,
      MUL_TRAV_HI_SIN
   } mul_sel_type;

   typedef struct packed {
      logic                  load;
      mul_sel_type           mul_sel;
      logic                  travel_ld;
      logic                  mhi_ld;
      logic                  acc_ld;
      logic                  head_upd;
      logic                  cordic_init;
      logic                  cordic_step;
      logic [ATAN_IDX_W-1:0] step;
      logic                  x_upd;
      logic                  y_upd;
      logic                  out_ld;
   } ddo_cmd_type;

endpackage

// File: src/ddo_csr.sv
module ddo_csr import ddo_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic [CFG_W-1:0]      mm_per_tick,
   output logic [CFG_W-1:0]      angle_per_mm
);

   logic [CFG_W-1:0] mm_per_tick_ff;
   logic [CFG_W-1:0] angle_per_mm_ff;
   logic             wr_en;
   logic             reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1];

   // register writes, upper data bits dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         mm_per_tick_ff  <= MM_PER_TICK_RESET;
         angle_per_mm_ff <= ANGLE_PER_MM_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            REG_MM_PER_TICK:  mm_per_tick_ff  <= csr_pwdata[CFG_W-1:0];
            REG_ANGLE_PER_MM: angle_per_mm_ff <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_MM_PER_TICK:  csr_prdata = {{(CSR_DATA_W-CFG_W){1'b0}}, mm_per_tick_ff};
         REG_ANGLE_PER_MM: csr_prdata = {{(CSR_DATA_W-CFG_W){1'b0}}, angle_per_mm_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign mm_per_tick  = mm_per_tick_ff;
   assign angle_per_mm = angle_per_mm_ff;

endmodule

// File: src/ddo_ctrl.sv
module ddo_ctrl import ddo_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ddo_cmd_type cmd
);

   localparam logic [ATAN_IDX_W-1:0] LAST_STEP = ATAN_IDX_W'(CORDIC_STEPS - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_TRAV,
      ST_MUL_DIFF,
      ST_MUL_HLO,
      ST_MUL_HHI,
      ST_HEAD,
      ST_CINIT,
      ST_CORDIC,
      ST_MUL_XLO,
      ST_MUL_XHI,
      ST_MUL_YLO,
      ST_MUL_YHI,
      ST_YACC,
      ST_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic [ATAN_IDX_W-1:0] step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Each multiply state issues one product; the next state consumes it.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.mul_sel  = MUL_SUM_MM;
      cmd.step     = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL_TRAV;
            end
         end
         ST_MUL_TRAV: begin
            cmd.mul_sel = MUL_SUM_MM;
            state_in    = ST_MUL_DIFF;
         end
         ST_MUL_DIFF: begin
            cmd.mul_sel   = MUL_DIFF_MM;
            cmd.travel_ld = 1'b1;
            state_in      = ST_MUL_HLO;
         end
         ST_MUL_HLO: begin
            cmd.mul_sel = MUL_HEAD_LO;
            cmd.mhi_ld  = 1'b1;
            state_in    = ST_MUL_HHI;
         end
         ST_MUL_HHI: begin
            cmd.mul_sel = MUL_HEAD_HI;
            cmd.acc_ld  = 1'b1;
            state_in    = ST_HEAD;
         end
         ST_HEAD: begin
            cmd.head_upd = 1'b1;
            state_in     = ST_CINIT;
         end
         ST_CINIT: begin
            cmd.cordic_init = 1'b1;
            step_in         = '0;
            state_in        = ST_CORDIC;
         end
         ST_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_MUL_XLO;
            end else begin
               step_in = step_ff + ATAN_IDX_W'(1);
            end
         end
         ST_MUL_XLO: begin
            cmd.mul_sel = MUL_TRAV_LO_COS;
            state_in    = ST_MUL_XHI;
         end
         ST_MUL_XHI: begin
            cmd.mul_sel = MUL_TRAV_HI_COS;
            cmd.acc_ld  = 1'b1;
            state_in    = ST_MUL_YLO;
         end
         ST_MUL_YLO: begin
            cmd.mul_sel = MUL_TRAV_LO_SIN;
            cmd.x_upd   = 1'b1;
            state_in    = ST_MUL_YHI;
         end
         ST_MUL_YHI: begin
            cmd.mul_sel = MUL_TRAV_HI_SIN;
            cmd.acc_ld  = 1'b1;
            state_in    = ST_YACC;
         end
         ST_YACC: begin
            cmd.y_upd = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_ld   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// File: src/ddo_dpath.sv
module ddo_dpath import ddo_pkg::*; #(
   parameter int ANGLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ddo_cmd_type              cmd,
   input  logic [COUNT_W-1:0]       left_count,
   input  logic [COUNT_W-1:0]       right_count,
   input  logic [CFG_W-1:0]         mm_per_tick,
   input  logic [CFG_W-1:0]         angle_per_mm,
   output logic signed [POSE_W-1:0] x_pose,
   output logic signed [POSE_W-1:0] y_pose,
   output logic [HOUT_W-1:0]        heading
);

   localparam int PHASE_PAD = CORDIC_W - ANGLE_BITS;

   // sample state
   logic [COUNT_W-1:0]          prev_left_ff, prev_right_ff;
   logic [COUNT_W-1:0]          dl, dr;
   logic signed [DELTA_W-1:0]   sum_ff, sum_in, diff_ff, diff_in;

   // shared multiplier
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]    product_ff, product_in;
   logic [MUL_B_W-1:0]          mm_ext, ang_ext;

   // product accumulation
   logic signed [PROD_W-1:0]    trav_sum;
   logic signed [TRAVEL_W-1:0]  travel_ff;
   logic [SPLIT_H-1:0]          mhi_ff;
   logic [ACC_W-1:0]            acc_ff;
   logic [HEAD_W-1:0]           head_sum;
   logic [ACC_W-1:0]            pose_sum;
   logic [POSE_W-1:0]           pose_step;

   // heading and pose
   logic [ANGLE_BITS-1:0]       heading_ff, heading_in;
   logic [ANGLE_BITS+HOUT_W-1:0] heading_pad;
   logic [POSE_W-1:0]           x_acc_ff, y_acc_ff;
   logic signed [POSE_W-1:0]    x_pose_ff, y_pose_ff;
   logic [HOUT_W-1:0]           heading_out_ff;

   // CORDIC
   logic [CORDIC_W-1:0]         phase, phase_rnd, resid;
   logic [1:0]                  quad_in, quad_ff;
   logic signed [CORDIC_W-1:0]  cx_ff, cy_ff, cz_ff;
   logic signed [CORDIC_W-1:0]  cx_sh, cy_sh, c_atan;
   logic signed [CORDIC_W-1:0]  cos_v, sin_v;
   logic signed [MUL_B_W-1:0]   cos_ext, sin_ext;
   logic [MUL_A_W-1:0]          trav_lo_ext, trav_hi_ext;

   // wrapped count deltas, sign extended
   assign dl      = left_count - prev_left_ff;
   assign dr      = right_count - prev_right_ff;
   assign sum_in  = {{(DELTA_W-COUNT_W){dl[COUNT_W-1]}}, dl}
                  + {{(DELTA_W-COUNT_W){dr[COUNT_W-1]}}, dr};
   assign diff_in = {{(DELTA_W-COUNT_W){dr[COUNT_W-1]}}, dr}
                  - {{(DELTA_W-COUNT_W){dl[COUNT_W-1]}}, dl};

   // multiplier operand select
   assign mm_ext      = {{(MUL_B_W-CFG_W){1'b0}}, mm_per_tick};
   assign ang_ext     = {{(MUL_B_W-CFG_W){1'b0}}, angle_per_mm};
   assign cos_ext     = {cos_v[CORDIC_W-1], cos_v};
   assign sin_ext     = {sin_v[CORDIC_W-1], sin_v};
   assign trav_lo_ext = {{(MUL_A_W-SPLIT_T){1'b0}}, travel_ff[SPLIT_T-1:0]};
   assign trav_hi_ext = {{(MUL_A_W-(TRAVEL_W-SPLIT_T)){travel_ff[TRAVEL_W-1]}},
                         travel_ff[TRAVEL_W-1:SPLIT_T]};

   always_comb begin
      case (cmd.mul_sel)
         MUL_SUM_MM: begin
            mul_a = sum_ff;
            mul_b = mm_ext;
         end
         MUL_DIFF_MM: begin
            mul_a = diff_ff;
            mul_b = mm_ext;
         end
         MUL_HEAD_LO: begin
            mul_a = {{(MUL_A_W-SPLIT_H){1'b0}}, product_ff[SPLIT_H-1:0]};
            mul_b = ang_ext;
         end
         MUL_HEAD_HI: begin
            mul_a = {{(MUL_A_W-SPLIT_H){1'b0}}, mhi_ff};
            mul_b = ang_ext;
         end
         MUL_TRAV_LO_COS: begin
            mul_a = trav_lo_ext;
            mul_b = cos_ext;
         end
         MUL_TRAV_HI_COS: begin
            mul_a = trav_hi_ext;
            mul_b = cos_ext;
         end
         MUL_TRAV_LO_SIN: begin
            mul_a = trav_lo_ext;
            mul_b = sin_ext;
         end
         MUL_TRAV_HI_SIN: begin
            mul_a = trav_hi_ext;
            mul_b = sin_ext;
         end
         default: begin
            mul_a = sum_ff;
            mul_b = mm_ext;
         end
      endcase
   end

   assign product_in = mul_a * mul_b;

   // travel in 1/256 mm, rounded, floor division
   assign trav_sum = product_ff + PROD_W'(256);

   // heading step: bits above 2^32 of the rounded product, modulo 2^56
   assign head_sum   = acc_ff[HEAD_W-1:0]
                     + {product_ff[HEAD_W-SPLIT_H-1:0], {SPLIT_H{1'b0}}}
                     + (HEAD_W'(1) << 31);
   assign heading_in = heading_ff + head_sum[32+ANGLE_BITS-1:32];

   // pose step: rounded product over 2^30, modulo 2^62
   assign pose_sum  = acc_ff
                    + {product_ff[ACC_W-SPLIT_T-1:0], {SPLIT_T{1'b0}}}
                    + (ACC_W'(1) << (POSE_SHIFT - 1));
   assign pose_step = pose_sum[POSE_SHIFT+POSE_W-1:POSE_SHIFT];

   // quadrant split of the phase
   assign phase     = {heading_ff, {PHASE_PAD{1'b0}}};
   assign phase_rnd = phase + (CORDIC_W'(1) << 29);
   assign quad_in   = phase_rnd[CORDIC_W-1:CORDIC_W-2];
   assign resid     = phase - {quad_in, {(CORDIC_W-2){1'b0}}};

   // one CORDIC rotation
   assign cx_sh  = cx_ff >>> cmd.step;
   assign cy_sh  = cy_ff >>> cmd.step;
   assign c_atan = atan_turn(cmd.step);

   // rotate the result back into its quadrant
   always_comb begin
      case (quad_ff)
         QUAD_ZERO: begin
            cos_v = cx_ff;
            sin_v = cy_ff;
         end
         QUAD_QUARTER: begin
            cos_v = -cy_ff;
            sin_v = cx_ff;
         end
         QUAD_HALF: begin
            cos_v = -cx_ff;
            sin_v = -cy_ff;
         end
         QUAD_THREE_QUARTER: begin
            cos_v = cy_ff;
            sin_v = -cx_ff;
         end
         default: begin
            cos_v = cx_ff;
            sin_v = cy_ff;
         end
      endcase
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
         heading_ff    <= '0;
         x_acc_ff      <= '0;
         y_acc_ff      <= '0;
      end else begin
         if (cmd.load) begin
            prev_left_ff  <= left_count;
            prev_right_ff <= right_count;
         end
         if (cmd.head_upd) begin
            heading_ff <= heading_in;
         end
         if (cmd.x_upd) begin
            x_acc_ff <= x_acc_ff + pose_step;
         end
         if (cmd.y_upd) begin
            y_acc_ff <= y_acc_ff + pose_step;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      product_ff <= product_in;
      if (cmd.load) begin
         sum_ff  <= sum_in;
         diff_ff <= diff_in;
      end
      if (cmd.travel_ld) begin
         travel_ff <= trav_sum[TRAVEL_SHIFT+TRAVEL_W-1:TRAVEL_SHIFT];
      end
      if (cmd.mhi_ld) begin
         mhi_ff <= product_ff[HEAD_W-1:SPLIT_H];
      end
      if (cmd.acc_ld) begin
         acc_ff <= product_ff[ACC_W-1:0];
      end
      if (cmd.cordic_init) begin
         quad_ff <= quad_in;
         cx_ff   <= CORDIC_GAIN;
         cy_ff   <= '0;
         cz_ff   <= resid;
      end else if (cmd.cordic_step) begin
         if (!cz_ff[CORDIC_W-1]) begin
            cx_ff <= cx_ff - cy_sh;
            cy_ff <= cy_ff + cx_sh;
            cz_ff <= cz_ff - c_atan;
         end else begin
            cx_ff <= cx_ff + cy_sh;
            cy_ff <= cy_ff - cx_sh;
            cz_ff <= cz_ff + c_atan;
         end
      end
   end

   // result register
   assign heading_pad = {heading_ff, {HOUT_W{1'b0}}};

   always_ff @(posedge clock) begin
      if (cmd.out_ld) begin
         x_pose_ff      <= x_acc_ff;
         y_pose_ff      <= y_acc_ff;
         heading_out_ff <= heading_pad[ANGLE_BITS+HOUT_W-1 -: HOUT_W];
      end
   end

   assign x_pose  = x_pose_ff;
   assign y_pose  = y_pose_ff;
   assign heading = heading_out_ff;

endmodule

// File: src/differential_drive_odometry_unit.sv
// Differential-drive odometry. Each input beat carries both absolute wheel
// encoder counts; the unit forms the wrapped tick deltas, scales them by
// mm_per_tick (byte address 0) and angle_per_mm (byte address 4), adds the
// heading change, then adds travel times cos/sin of the new heading (from an
// iterative CORDIC) to x and y. One result beat per input beat: x_pose and
// y_pose in 1/256 mm, heading as a 16-bit binary angle. One item is worked
// at a time and makes eight passes through one shared 34x33 multiplier, with
// one CORDIC iteration per cycle. The result register holds a finished beat
// while the next item is accepted and worked; the unit only waits at the end
// of an item if the previous result has not been taken.
module differential_drive_odometry_unit import ddo_pkg::*; #(
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [COUNT_W-1:0]       req_left_count,
   input  logic [COUNT_W-1:0]       req_right_count,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [POSE_W-1:0] rsp_x_pose,
   output logic signed [POSE_W-1:0] rsp_y_pose,
   output logic [HOUT_W-1:0]        rsp_heading,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [CSR_DATA_W-1:0]    csr_pwdata,
   output logic [CSR_DATA_W-1:0]    csr_prdata,
   output logic                     csr_pready
);

   logic [CFG_W-1:0] mm_per_tick;
   logic [CFG_W-1:0] angle_per_mm;
   ddo_cmd_type      cmd;

   ddo_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .mm_per_tick  (mm_per_tick),
      .angle_per_mm (angle_per_mm)
   );

   ddo_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ddo_dpath #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .left_count   (req_left_count),
      .right_count  (req_right_count),
      .mm_per_tick  (mm_per_tick),
      .angle_per_mm (angle_per_mm),
      .x_pose       (rsp_x_pose),
      .y_pose       (rsp_y_pose),
      .heading      (rsp_heading)
   );

endmodule
